>>> rtl/core/mad_pkg.sv
// Package with the widths, constants and handshake types of the moving-average duty unit.
package mad_pkg;

   localparam int WINDOW   = 16;
   localparam int SAMPLE_W = 12;
   localparam int AVG_W    = 12;
   localparam int DUTY_W   = 8;
   localparam int PCT_W    = 7;

   localparam int SUM_W    = $clog2(WINDOW * 4095 + 1);
   localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W   = $clog2(WINDOW + 1);

   localparam int ADC_SHIFT  = 10;
   localparam int DUTY_SHIFT = 8;
   localparam int DUTY_MAX   = (1 << DUTY_SHIFT) - 1;
   localparam int ADC_FULL   = (1 << ADC_SHIFT) - 1;
   localparam int PCT_MAX    = 100;

   localparam int DIV_W    = AVG_W + DUTY_W;
   localparam int SHIFT_W  = $clog2(DIV_W);

   typedef struct packed {
      logic               start;
      logic [DIV_W-1:0]   dividend;
      logic [SHIFT_W-1:0] shift;
   } div_cmd_type;

   typedef struct packed {
      logic              done;
      logic [DIV_W-1:0]  quotient;
   } div_rsp_type;

endpackage

>>> rtl/core/mad_ring.sv
// Sample ring memory with one write port and a registered read port.
module mad_ring (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [mad_pkg::SLOT_W-1:0]    wr_slot,
   input  logic [mad_pkg::SAMPLE_W-1:0]  wr_data,
   input  logic [mad_pkg::SLOT_W-1:0]    rd_slot,
   output logic [mad_pkg::SAMPLE_W-1:0]  rd_data
);
   import mad_pkg::*;

   logic [SAMPLE_W-1:0] mem_ff [WINDOW];
   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_slot] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_slot];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/mad_divider.sv
// Shared divider by two to the power shift minus one, one registered quotient per command.
module mad_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  mad_pkg::div_cmd_type  cmd,
   output mad_pkg::div_rsp_type  rsp
);
   import mad_pkg::*;

   logic               done_ff;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [DIV_W:0]     folded;

   // The quotient is exact while it stays below two to the power shift.
   always_comb begin
      folded = {1'b0, cmd.dividend} + {1'b0, cmd.dividend >> cmd.shift}
               + (DIV_W + 1)'(1);
      quo_in = DIV_W'(folded >> cmd.shift);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= cmd.start;
      end
      if (cmd.start) begin
         quo_ff <= quo_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

>>> rtl/core/pot_moving_average_to_duty_unit.sv
// Top level: sample ring, running sum and the sequencer around the shared divider.
//
//   channel   direction   handshake             payload
//   req       in          req_valid/req_stall   req_sample
//   rsp       out         rsp_valid/rsp_stall   rsp_average, rsp_duty, rsp_percent,
//                                                rsp_percent_changed
//
// A fill-phase word passes the accept and the ring and sum update; a later word also has the
// duty division issued by that update, the percent division, and loading the result.
// Reset clears the sum, slot, fill count and change history; ring contents are not cleared.
// A finished result waits in the output register while the next word is accepted; a newer
// result waits in the sequencer, with the input stalled, until the previous one is taken.
module pot_moving_average_to_duty_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mad_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mad_pkg::AVG_W-1:0]     rsp_average,
   output logic [mad_pkg::DUTY_W-1:0]    rsp_duty,
   output logic [mad_pkg::PCT_W-1:0]     rsp_percent,
   output logic                          rsp_percent_changed
);
   import mad_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      UPDATE,
      DUTY,
      PCT,
      SEND
   } state_type;

   state_type          state_ff, state_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [AVG_W-1:0]   avg_ff, avg_in;
   logic [DUTY_W-1:0]  duty_ff, duty_in;
   logic [PCT_W-1:0]   pct_ff, pct_in;
   logic [PCT_W-1:0]   last_pct_ff, last_pct_in;
   logic               last_valid_ff, last_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [AVG_W-1:0]   rsp_avg_ff, rsp_avg_in;
   logic [DUTY_W-1:0]  rsp_duty_ff, rsp_duty_in;
   logic [PCT_W-1:0]   rsp_pct_ff, rsp_pct_in;
   logic               rsp_chg_ff, rsp_chg_in;

   logic               filling;
   logic               ring_wr;
   logic [SAMPLE_W-1:0] old_sample;
   logic [SUM_W-1:0]   sum_next;
   logic [AVG_W-1:0]   avg_c;
   logic [DUTY_W-1:0]  duty_c;
   logic [PCT_W-1:0]   pct_c;
   div_cmd_type        div_cmd;
   div_rsp_type        div_rsp;

   mad_ring u_ring (
      .clock   (clock),
      .wr_en   (ring_wr),
      .wr_slot (slot_ff),
      .wr_data (sample_ff),
      .rd_slot (slot_ff),
      .rd_data (old_sample)
   );

   mad_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   assign filling = (fill_ff < FILL_W'(WINDOW));

   always_comb begin
      if (filling) begin
         sum_next = sum_ff + SUM_W'(sample_ff);
      end else begin
         sum_next = sum_ff - SUM_W'(old_sample) + SUM_W'(sample_ff);
      end
      avg_c  = AVG_W'(sum_next / SUM_W'(WINDOW));
      duty_c = (div_rsp.quotient > DIV_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX)
                                                      : div_rsp.quotient[DUTY_W-1:0];
      pct_c  = (div_rsp.quotient > DIV_W'(PCT_MAX)) ? PCT_W'(PCT_MAX)
                                                     : div_rsp.quotient[PCT_W-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      sample_in     = sample_ff;
      sum_in        = sum_ff;
      slot_in       = slot_ff;
      fill_in       = fill_ff;
      avg_in        = avg_ff;
      duty_in       = duty_ff;
      pct_in        = pct_ff;
      last_pct_in   = last_pct_ff;
      last_valid_in = last_valid_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_avg_in    = rsp_avg_ff;
      rsp_duty_in   = rsp_duty_ff;
      rsp_pct_in    = rsp_pct_ff;
      rsp_chg_in    = rsp_chg_ff;
      ring_wr       = 1'b0;
      div_cmd       = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               state_in  = UPDATE;
            end
         end
         UPDATE: begin
            ring_wr = 1'b1;
            sum_in  = sum_next;
            slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + SLOT_W'(1);
            if (filling) begin
               fill_in  = fill_ff + FILL_W'(1);
               state_in = IDLE;
            end else begin
               avg_in           = avg_c;
               div_cmd.start    = 1'b1;
               div_cmd.dividend = DIV_W'(avg_c) * DIV_W'(DUTY_MAX);
               div_cmd.shift    = SHIFT_W'(ADC_SHIFT);
               state_in         = DUTY;
            end
         end
         DUTY: begin
            if (div_rsp.done) begin
               duty_in          = duty_c;
               div_cmd.start    = 1'b1;
               div_cmd.dividend = DIV_W'(duty_c) * DIV_W'(PCT_MAX);
               div_cmd.shift    = SHIFT_W'(DUTY_SHIFT);
               state_in         = PCT;
            end
         end
         PCT: begin
            if (div_rsp.done) begin
               pct_in = pct_c;
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_in  = 1'b1;
                  rsp_avg_in    = avg_ff;
                  rsp_duty_in   = duty_ff;
                  rsp_pct_in    = pct_c;
                  rsp_chg_in    = !last_valid_ff || (pct_c != last_pct_ff);
                  last_pct_in   = pct_c;
                  last_valid_in = 1'b1;
                  state_in      = IDLE;
               end else begin
                  state_in = SEND;
               end
            end
         end
         SEND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_avg_in    = avg_ff;
               rsp_duty_in   = duty_ff;
               rsp_pct_in    = pct_ff;
               rsp_chg_in    = !last_valid_ff || (pct_ff != last_pct_ff);
               last_pct_in   = pct_ff;
               last_valid_in = 1'b1;
               state_in      = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         sum_ff        <= '0;
         slot_ff       <= '0;
         fill_ff       <= '0;
         last_pct_ff   <= '0;
         last_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sum_ff        <= sum_in;
         slot_ff       <= slot_in;
         fill_ff       <= fill_in;
         last_pct_ff   <= last_pct_in;
         last_valid_ff <= last_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      avg_ff      <= avg_in;
      duty_ff     <= duty_in;
      pct_ff      <= pct_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_duty_ff <= rsp_duty_in;
      rsp_pct_ff  <= rsp_pct_in;
      rsp_chg_ff  <= rsp_chg_in;
   end

   assign req_stall           = (state_ff != IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_average         = rsp_avg_ff;
   assign rsp_duty            = rsp_duty_ff;
   assign rsp_percent         = rsp_pct_ff;
   assign rsp_percent_changed = rsp_chg_ff;

endmodule

>>> rtl/core/mad_checker.sv
// Port checker for the moving-average duty unit and its bind to the top level.
module mad_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [mad_pkg::SAMPLE_W-1:0]  req_sample,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [mad_pkg::AVG_W-1:0]     rsp_average,
   input logic [mad_pkg::DUTY_W-1:0]    rsp_duty,
   input logic [mad_pkg::PCT_W-1:0]     rsp_percent,
   input logic                          rsp_percent_changed
);
   import mad_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_sample))
      else $error("stalled input word changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_average) && $stable(rsp_duty)
         && $stable(rsp_percent) && $stable(rsp_percent_changed))
      else $error("stalled result word changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted again in the cycle after an accepted word");

   a_new_result_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result word appeared while the unit was idle");

   a_percent_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_percent <= PCT_W'(PCT_MAX))
      else $error("percentage above its maximum");

endmodule

bind pot_moving_average_to_duty_unit mad_checker u_mad_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_sample          (req_sample),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_average         (rsp_average),
   .rsp_duty            (rsp_duty),
   .rsp_percent         (rsp_percent),
   .rsp_percent_changed (rsp_percent_changed)
);
